>>> rtl/pvkf_pkg.sv
`timescale 1ns / 1ps

package pvkf_pkg;

   // The result channel carries one position and one velocity per axis.
   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;

   localparam logic [1:0] REG_ACCEL_SIGMA   = 2'd0;
   localparam logic [1:0] REG_MEAS_VAR      = 2'd1;
   localparam logic [1:0] REG_INIT_POS_VAR  = 2'd2;
   localparam logic [1:0] REG_INIT_VEL_VAR  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_WB,
      S_DSET,
      S_DIV,
      S_DFIN,
      S_OUT
   } state_type;

   // One entry per operation of the shared multiply-add unit or the divider.
   typedef enum logic [4:0] {
      ST_DT2,
      ST_G,
      ST_S2,
      ST_S2G,
      ST_QVV,
      ST_QPV,
      ST_QPP,
      ST_T,
      ST_PPW,
      ST_PP,
      ST_PV,
      ST_VV,
      ST_POS,
      ST_S,
      ST_R,
      ST_KP,
      ST_KV,
      ST_P,
      ST_V,
      ST_NPP,
      ST_NPV,
      ST_NVV
   } step_type;

endpackage

>>> rtl/position_velocity_kalman_filter_unit.sv
`timescale 1ns / 1ps

// Constant-velocity Kalman filter over three independent axes in signed fixed
// point with FRAC_BITS fraction bits. The first transfer after reset only loads
// the track and gives no result; each later transfer gives one result. One
// shared 32x32 multiplier with a saturating adder runs every product and sum,
// and a bit-serial divider forms both gains of each axis at one quotient bit per
// cycle. The unit takes no new transfer until the result of the last one is in
// the output register; the first, loading item leaves it idle and ready.
module position_velocity_kalman_filter_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [23:0]        req_time_step,
   input  logic signed [31:0] req_meas_x,
   input  logic signed [31:0] req_meas_y,
   input  logic signed [31:0] req_meas_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_est_pos_x,
   output logic signed [31:0] rsp_est_pos_y,
   output logic signed [31:0] rsp_est_pos_z,
   output logic signed [31:0] rsp_est_vel_x,
   output logic signed [31:0] rsp_est_vel_y,
   output logic signed [31:0] rsp_est_vel_z,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW);
   localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [64:0] RND  = 65'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [64:0] M_MAX = 65'sd2147483647;
   localparam logic signed [64:0] M_MIN = -65'sd2147483648;
   localparam logic signed [35:0] A_MAX = 36'sd2147483647;
   localparam logic signed [35:0] A_MIN = -36'sd2147483648;
   localparam logic [NW-1:0] Q_MAX = NW'(32'h7fffffff);
   localparam logic [NW-1:0] Q_NEG = NW'(32'h80000000);

   pvkf_pkg::state_type state_ff, state_in;
   pvkf_pkg::step_type  step_ff, step_in;
   logic [pvkf_pkg::AXIS_W-1:0] axis_ff, axis_in;

   logic [23:0] sigma_ff, meas_var_ff, init_pos_ff, init_vel_ff;
   logic        started_ff;
   logic [23:0] dt_ff;
   logic signed [31:0] meas_ff [pvkf_pkg::NUM_AXES];
   logic signed [31:0] pos_ff  [pvkf_pkg::NUM_AXES];
   logic signed [31:0] vel_ff  [pvkf_pkg::NUM_AXES];
   logic signed [31:0] ppp_ff  [pvkf_pkg::NUM_AXES];
   logic signed [31:0] ppv_ff  [pvkf_pkg::NUM_AXES];
   logic signed [31:0] pvv_ff  [pvkf_pkg::NUM_AXES];

   logic signed [31:0] dt2_ff, g_ff, s2_ff, s2g_ff, qvv_ff, qpv_ff, qpp_ff;
   logic signed [31:0] t_ff, pp_ff, pv_ff, vv_ff, ppos_ff, s_ff, r_ff, kp_ff, kv_ff;
   logic signed [35:0] wide_ff;
   logic signed [63:0] prod_ff;

   logic [NW-1:0] dnum_ff;
   logic [32:0]   drem_ff;
   logic [31:0]   dden_ff;
   logic          dneg_ff, dzero_ff;
   logic [CW-1:0] dcnt_ff;

   logic        rsp_valid_ff;
   logic signed [31:0] out_pos_ff [pvkf_pkg::NUM_AXES];
   logic signed [31:0] out_vel_ff [pvkf_pkg::NUM_AXES];

   logic signed [31:0] dt_s, sig_s, mul_a, mul_b, mres, sres, dsrc, qres;
   logic signed [35:0] add1, add2, sum36;
   logic signed [64:0] rnd, shf;
   logic [32:0]        rem_sh;
   logic               ge, req_xfer, out_go, last_axis;
   logic [31:0]        nmag, dmag;

   assign dt_s      = 32'(dt_ff);
   assign sig_s     = 32'(sigma_ff);
   assign req_ready = (state_ff == pvkf_pkg::S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_go    = !rsp_valid_ff || rsp_ready;
   assign last_axis = (axis_ff == pvkf_pkg::AXIS_W'(pvkf_pkg::NUM_AXES - 1));

   // Operand selection for the shared multiply-add unit.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      add1  = '0;
      add2  = '0;
      case (step_ff)
         pvkf_pkg::ST_DT2: begin mul_a = dt_s;   mul_b = dt_s;   end
         pvkf_pkg::ST_G:   begin mul_a = dt2_ff; mul_b = HALF;   end
         pvkf_pkg::ST_S2:  begin mul_a = sig_s;  mul_b = sig_s;  end
         pvkf_pkg::ST_S2G: begin mul_a = s2_ff;  mul_b = g_ff;   end
         pvkf_pkg::ST_QVV: begin mul_a = s2_ff;  mul_b = dt2_ff; end
         pvkf_pkg::ST_QPV: begin mul_a = s2g_ff; mul_b = dt_s;   end
         pvkf_pkg::ST_QPP: begin mul_a = s2g_ff; mul_b = g_ff;   end
         pvkf_pkg::ST_T: begin
            mul_a = dt_s; mul_b = pvv_ff[axis_ff]; add1 = 36'(ppv_ff[axis_ff]);
         end
         pvkf_pkg::ST_PPW: begin
            mul_a = dt_s; mul_b = ppv_ff[axis_ff]; add1 = 36'(ppp_ff[axis_ff]);
         end
         pvkf_pkg::ST_PP: begin
            mul_a = dt_s; mul_b = t_ff; add1 = wide_ff; add2 = 36'(qpp_ff);
         end
         pvkf_pkg::ST_PV: begin add1 = 36'(t_ff); add2 = 36'(qpv_ff); end
         pvkf_pkg::ST_VV: begin add1 = 36'(pvv_ff[axis_ff]); add2 = 36'(qvv_ff); end
         pvkf_pkg::ST_POS: begin
            mul_a = dt_s; mul_b = vel_ff[axis_ff]; add1 = 36'(pos_ff[axis_ff]);
         end
         pvkf_pkg::ST_S: begin add1 = 36'(32'(meas_var_ff)); add2 = 36'(pp_ff); end
         pvkf_pkg::ST_R: begin
            mul_a = ppos_ff; mul_b = ONE; add1 = 36'(meas_ff[axis_ff]);
         end
         pvkf_pkg::ST_P:   begin mul_a = kp_ff; mul_b = r_ff; add1 = 36'(ppos_ff); end
         pvkf_pkg::ST_V: begin
            mul_a = kv_ff; mul_b = r_ff; add1 = 36'(vel_ff[axis_ff]);
         end
         pvkf_pkg::ST_NPP: begin mul_a = kp_ff; mul_b = pp_ff; add1 = 36'(pp_ff); end
         pvkf_pkg::ST_NPV: begin mul_a = kp_ff; mul_b = pv_ff; add1 = 36'(pv_ff); end
         pvkf_pkg::ST_NVV: begin mul_a = kv_ff; mul_b = pv_ff; add1 = 36'(vv_ff); end
         default: begin end
      endcase
   end

   // Round half up, then saturate the product; the sum is exact before saturation.
   always_comb begin
      rnd = 65'(prod_ff) + RND;
      shf = rnd >>> FRAC_BITS;
      if (shf > M_MAX) begin
         mres = 32'sh7fffffff;
      end else if (shf < M_MIN) begin
         mres = 32'sh80000000;
      end else begin
         mres = shf[31:0];
      end
      if (step_ff == pvkf_pkg::ST_R || step_ff == pvkf_pkg::ST_NPP ||
          step_ff == pvkf_pkg::ST_NPV || step_ff == pvkf_pkg::ST_NVV) begin
         sum36 = add1 + add2 - 36'(mres);
      end else begin
         sum36 = add1 + add2 + 36'(mres);
      end
      if (sum36 > A_MAX) begin
         sres = 32'sh7fffffff;
      end else if (sum36 < A_MIN) begin
         sres = 32'sh80000000;
      end else begin
         sres = sum36[31:0];
      end
   end

   // Divider operands and result.
   always_comb begin
      dsrc   = (step_ff == pvkf_pkg::ST_KP) ? pp_ff : pv_ff;
      nmag   = dsrc[31] ? 32'(-dsrc) : 32'(dsrc);
      dmag   = s_ff[31] ? 32'(-s_ff) : 32'(s_ff);
      rem_sh = {drem_ff[31:0], dnum_ff[NW-1]};
      ge     = (rem_sh >= {1'b0, dden_ff});
      if (dzero_ff) begin
         qres = '0;
      end else if (!dneg_ff) begin
         qres = (dnum_ff > Q_MAX) ? 32'sh7fffffff : dnum_ff[31:0];
      end else begin
         qres = (dnum_ff > Q_NEG) ? 32'sh80000000 : 32'(-dnum_ff[31:0]);
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      case (state_ff)
         pvkf_pkg::S_IDLE: begin
            if (req_xfer && started_ff) begin
               state_in = pvkf_pkg::S_MUL;
               step_in  = pvkf_pkg::ST_DT2;
               axis_in  = '0;
            end
         end
         pvkf_pkg::S_MUL: state_in = pvkf_pkg::S_WB;
         pvkf_pkg::S_WB: begin
            if (step_ff == pvkf_pkg::ST_R) begin
               state_in = pvkf_pkg::S_DSET;
               step_in  = pvkf_pkg::ST_KP;
            end else if (step_ff == pvkf_pkg::ST_NVV) begin
               if (last_axis) begin
                  state_in = pvkf_pkg::S_OUT;
               end else begin
                  state_in = pvkf_pkg::S_MUL;
                  step_in  = pvkf_pkg::ST_T;
                  axis_in  = axis_ff + 1'b1;
               end
            end else begin
               state_in = pvkf_pkg::S_MUL;
               step_in  = pvkf_pkg::step_type'(5'(step_ff) + 5'd1);
            end
         end
         pvkf_pkg::S_DSET: state_in = pvkf_pkg::S_DIV;
         pvkf_pkg::S_DIV: begin
            if (dcnt_ff == CW'(NW - 1)) begin
               state_in = pvkf_pkg::S_DFIN;
            end
         end
         pvkf_pkg::S_DFIN: begin
            if (step_ff == pvkf_pkg::ST_KP) begin
               state_in = pvkf_pkg::S_DSET;
               step_in  = pvkf_pkg::ST_KV;
            end else begin
               state_in = pvkf_pkg::S_MUL;
               step_in  = pvkf_pkg::ST_P;
            end
         end
         pvkf_pkg::S_OUT: begin
            if (out_go) begin
               state_in = pvkf_pkg::S_IDLE;
            end
         end
         default: state_in = pvkf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvkf_pkg::S_IDLE;
         step_ff      <= pvkf_pkg::ST_DT2;
         axis_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sigma_ff     <= 24'd1310720;
         meas_var_ff  <= 24'd66;
         init_pos_ff  <= 24'd6554;
         init_vel_ff  <= 24'd72090;
         for (int i = 0; i < pvkf_pkg::NUM_AXES; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            ppp_ff[i] <= '0;
            ppv_ff[i] <= '0;
            pvv_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;

         if (csr_wr_en) begin
            case (csr_index)
               pvkf_pkg::REG_ACCEL_SIGMA:  sigma_ff    <= csr_wdata;
               pvkf_pkg::REG_MEAS_VAR:     meas_var_ff <= csr_wdata;
               pvkf_pkg::REG_INIT_POS_VAR: init_pos_ff <= csr_wdata;
               pvkf_pkg::REG_INIT_VEL_VAR: init_vel_ff <= csr_wdata;
               default: begin end
            endcase
         end

         if (req_xfer && !started_ff) begin
            started_ff <= 1'b1;
            pos_ff[0]  <= req_meas_x;
            pos_ff[1]  <= req_meas_y;
            pos_ff[2]  <= req_meas_z;
            for (int i = 0; i < pvkf_pkg::NUM_AXES; i++) begin
               vel_ff[i] <= '0;
               ppp_ff[i] <= 32'(init_pos_ff);
               ppv_ff[i] <= '0;
               pvv_ff[i] <= 32'(init_vel_ff);
            end
         end

         if (state_ff == pvkf_pkg::S_WB) begin
            case (step_ff)
               pvkf_pkg::ST_P:   pos_ff[axis_ff] <= sres;
               pvkf_pkg::ST_V:   vel_ff[axis_ff] <= sres;
               pvkf_pkg::ST_NPP: ppp_ff[axis_ff] <= sres;
               pvkf_pkg::ST_NPV: ppv_ff[axis_ff] <= sres;
               pvkf_pkg::ST_NVV: pvv_ff[axis_ff] <= sres;
               default: begin end
            endcase
         end

         if (state_ff == pvkf_pkg::S_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dt_ff      <= req_time_step;
         meas_ff[0] <= req_meas_x;
         meas_ff[1] <= req_meas_y;
         meas_ff[2] <= req_meas_z;
      end

      if (state_ff == pvkf_pkg::S_MUL) begin
         prod_ff <= mul_a * mul_b;
      end

      if (state_ff == pvkf_pkg::S_WB) begin
         wide_ff <= sum36;
         case (step_ff)
            pvkf_pkg::ST_DT2: dt2_ff  <= sres;
            pvkf_pkg::ST_G:   g_ff    <= sres;
            pvkf_pkg::ST_S2:  s2_ff   <= sres;
            pvkf_pkg::ST_S2G: s2g_ff  <= sres;
            pvkf_pkg::ST_QVV: qvv_ff  <= sres;
            pvkf_pkg::ST_QPV: qpv_ff  <= sres;
            pvkf_pkg::ST_QPP: qpp_ff  <= sres;
            pvkf_pkg::ST_T:   t_ff    <= sres;
            pvkf_pkg::ST_PP:  pp_ff   <= sres;
            pvkf_pkg::ST_PV:  pv_ff   <= sres;
            pvkf_pkg::ST_VV:  vv_ff   <= sres;
            pvkf_pkg::ST_POS: ppos_ff <= sres;
            pvkf_pkg::ST_S:   s_ff    <= sres;
            pvkf_pkg::ST_R:   r_ff    <= sres;
            default: begin end
         endcase
      end

      // The quotient bits shift into the numerator register as it empties.
      if (state_ff == pvkf_pkg::S_DSET) begin
         dnum_ff  <= NW'(nmag) << FRAC_BITS;
         drem_ff  <= '0;
         dden_ff  <= dmag;
         dneg_ff  <= dsrc[31] ^ s_ff[31];
         dzero_ff <= (s_ff == 32'sd0);
         dcnt_ff  <= '0;
      end else if (state_ff == pvkf_pkg::S_DIV) begin
         drem_ff <= ge ? (rem_sh - {1'b0, dden_ff}) : rem_sh;
         dnum_ff <= {dnum_ff[NW-2:0], ge};
         dcnt_ff <= dcnt_ff + 1'b1;
      end

      if (state_ff == pvkf_pkg::S_DFIN) begin
         if (step_ff == pvkf_pkg::ST_KP) begin
            kp_ff <= qres;
         end else begin
            kv_ff <= qres;
         end
      end

      if (state_ff == pvkf_pkg::S_OUT && out_go) begin
         for (int i = 0; i < pvkf_pkg::NUM_AXES; i++) begin
            out_pos_ff[i] <= pos_ff[i];
            out_vel_ff[i] <= vel_ff[i];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_est_pos_x = out_pos_ff[0];
   assign rsp_est_pos_y = out_pos_ff[1];
   assign rsp_est_pos_z = out_pos_ff[2];
   assign rsp_est_vel_x = out_vel_ff[0];
   assign rsp_est_vel_y = out_vel_ff[1];
   assign rsp_est_vel_z = out_vel_ff[2];

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pvkf_pkg::S_OUT))
      else $error("result raised outside the output state");

   a_load_only: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !started_ff) |=> (state_ff == pvkf_pkg::S_IDLE && started_ff))
      else $error("loading item did not return to idle");

   a_mul_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pvkf_pkg::S_MUL) |=> (state_ff == pvkf_pkg::S_WB))
      else $error("multiply not followed by write-back");

   a_div_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pvkf_pkg::S_DIV) |-> (step_ff == pvkf_pkg::ST_KP ||
                                         step_ff == pvkf_pkg::ST_KV))
      else $error("divider running outside a gain step");

endmodule
